[rtl/core/ffra_pkg.sv]
`default_nettype none
package ffra_pkg;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } ffra_state_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [2:0] STAT_ALLOC   = 3'd0;
  localparam logic [2:0] STAT_TOO_BIG = 3'd1;
  localparam logic [2:0] STAT_NO_FIT  = 3'd2;
  localparam logic [2:0] STAT_FREED   = 3'd3;
  localparam logic [2:0] STAT_EMPTY   = 3'd4;
  localparam logic [2:0] STAT_BUSY    = 3'd5;

  localparam logic [8:0] MEM_SIZE_RST = 9'd256;

  typedef struct packed {
    logic we;
    logic wdata;
  } ffra_map_ctl_t;

  typedef struct packed {
    logic init;
    logic step;
  } ffra_run_ctl_t;

  typedef struct packed {
    logic wr_alloc;
    logic wr_free;
  } ffra_slot_ctl_t;

endpackage
`default_nettype wire

[rtl/core/ffra_bitmap.sv]
`default_nettype none
module ffra_bitmap #(
  parameter int MEM_UNITS = 256
) (
  input  wire                            clk,
  input  ffra_pkg::ffra_map_ctl_t        map_ctl,
  input  wire [$clog2(MEM_UNITS)-1:0]    waddr,
  input  wire [$clog2(MEM_UNITS)-1:0]    raddr,
  output logic                           rdata
);
  import ffra_pkg::*;

  logic used_mem [MEM_UNITS];

  always_ff @(posedge clk) begin
    if (map_ctl.we) begin
      used_mem[waddr] <= map_ctl.wdata;
    end
    rdata <= used_mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/ffra_slots.sv]
`default_nettype none
module ffra_slots #(
  parameter int MEM_UNITS  = 256,
  parameter int PROC_SLOTS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  ffra_pkg::ffra_slot_ctl_t           slot_ctl,
  input  wire [$clog2(PROC_SLOTS)-1:0]       rd_idx,
  input  wire [$clog2(PROC_SLOTS)-1:0]       wr_idx,
  input  wire [$clog2(MEM_UNITS+1)-1:0]      wr_start,
  input  wire [$clog2(MEM_UNITS+1)-1:0]      wr_end,
  output logic                               rd_valid,
  output logic [$clog2(MEM_UNITS+1)-1:0]     rd_start,
  output logic [$clog2(MEM_UNITS+1)-1:0]     rd_end
);
  import ffra_pkg::*;

  localparam int CNT_W = $clog2(MEM_UNITS + 1);

  logic [PROC_SLOTS-1:0] valid_r;
  logic [CNT_W-1:0]      start_mem [PROC_SLOTS];
  logic [CNT_W-1:0]      end_mem   [PROC_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (slot_ctl.wr_alloc) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (slot_ctl.wr_free) begin
      valid_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_ctl.wr_alloc) begin
      start_mem[wr_idx] <= wr_start;
      end_mem[wr_idx]   <= wr_end;
    end
    rd_valid <= valid_r[rd_idx];
    rd_start <= start_mem[rd_idx];
    rd_end   <= end_mem[rd_idx];
  end

endmodule
`default_nettype wire

[rtl/core/ffra_run_unit.sv]
`default_nettype none
module ffra_run_unit #(
  parameter int MEM_UNITS = 256
) (
  input  wire                             clk,
  input  ffra_pkg::ffra_run_ctl_t         run_ctl,
  input  wire                             unit_used,
  input  wire [$clog2(MEM_UNITS+1)-1:0]   pos,
  input  wire [$clog2(MEM_UNITS+1)-1:0]   req,
  output logic                            hit,
  output logic [$clog2(MEM_UNITS+1)-1:0]  hit_start,
  output logic [$clog2(MEM_UNITS+1)-1:0]  largest
);
  import ffra_pkg::*;

  localparam int CNT_W = $clog2(MEM_UNITS + 1);

  logic [CNT_W-1:0] run_start_r;
  logic [CNT_W-1:0] run_len_r;
  logic [CNT_W-1:0] largest_r;
  logic [CNT_W-1:0] len_inc;

  assign len_inc   = CNT_W'(run_len_r + 1'b1);
  assign hit       = run_ctl.step && !unit_used && (len_inc >= req);
  assign hit_start = (run_len_r == '0) ? pos : run_start_r;
  assign largest   = largest_r;

  always_ff @(posedge clk) begin
    if (run_ctl.init) begin
      run_start_r <= '0;
      run_len_r   <= '0;
      largest_r   <= '0;
    end else if (run_ctl.step) begin
      if (unit_used) begin
        run_len_r <= '0;
      end else begin
        run_len_r <= len_inc;
        if (run_len_r == '0) begin
          run_start_r <= pos;
        end
        if (len_inc > largest_r) begin
          largest_r <= len_inc;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/first_fit_region_allocator_top.sv]
`default_nettype none
// First-fit allocator of contiguous memory units with one region per process slot. After
// reset the block clears its unit bitmap one unit per cycle, and only then takes the first
// request; configuration writes are taken at any time. Requests are handled one at a time
// by a sequencer around a single run-tracking compare unit and a one-port-per-side bitmap
// memory. An allocate looks up its slot, scans the bitmap unit by unit up to the end of the
// first fitting run and then marks each unit of that region; one that finds no fitting run
// scans the whole effective memory size. A rejected request goes from the slot lookup
// straight to its response, and a free clears each unit of its region. Each result waits
// for the output register to be free or read before it is loaded. A new request is
// accepted while the previous result still waits in the output register.
module first_fit_region_allocator_top #(
  parameter int MEM_UNITS  = 256,
  parameter int PROC_SLOTS = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_mode,
  input  wire [3:0]  in_process_id,
  input  wire [8:0]  in_request_size,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_region_start,
  output logic [8:0] out_region_end,
  output logic [8:0] out_largest_free,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [8:0]  cfg_mem_size
);
  import ffra_pkg::*;

  localparam int ADDR_W = $clog2(MEM_UNITS);
  localparam int CNT_W  = $clog2(MEM_UNITS + 1);
  localparam int SLOT_W = $clog2(PROC_SLOTS);

  ffra_state_t state_r, state_nxt;

  logic             mode_r;
  logic [3:0]       pid_r;
  logic [8:0]       req_r;
  logic [8:0]       mem_size_r;
  logic [CNT_W-1:0] seg_ptr_r, seg_ptr_nxt;
  logic [CNT_W-1:0] seg_end_r, seg_end_nxt;
  logic [CNT_W-1:0] seg_start_r, seg_start_nxt;
  logic [CNT_W-1:0] scan_pos_r, scan_pos_nxt;
  logic [2:0]       res_status_r, res_status_nxt;
  logic [7:0]       res_start_r, res_start_nxt;
  logic [8:0]       res_end_r, res_end_nxt;
  logic [8:0]       res_largest_r, res_largest_nxt;
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [7:0]       out_start_r;
  logic [8:0]       out_end_r;
  logic [8:0]       out_largest_r;

  ffra_map_ctl_t    map_ctl;
  ffra_run_ctl_t    run_ctl;
  ffra_slot_ctl_t   slot_ctl;

  logic [ADDR_W-1:0] map_raddr;
  logic              map_rdata;
  logic              slot_rd_valid;
  logic [CNT_W-1:0]  slot_rd_start;
  logic [CNT_W-1:0]  slot_rd_end;
  logic              run_hit;
  logic [CNT_W-1:0]  run_hit_start;
  logic [CNT_W-1:0]  run_largest;

  logic [31:0]       eff32;
  logic [31:0]       req32;
  logic [31:0]       pid32;
  logic [31:0]       in_pid32;
  logic [31:0]       nxt_pos32;
  logic [31:0]       start32;
  logic [31:0]       end32;
  logic [31:0]       largest32;
  logic [CNT_W-1:0]  req_cnt;
  logic              pid_ok;
  logic              scan_done;
  logic              seg_done;
  logic              resp_load;

  assign eff32     = (32'(mem_size_r) < 32'(MEM_UNITS)) ? 32'(mem_size_r) : 32'(MEM_UNITS);
  assign req32     = 32'(req_r);
  assign req_cnt   = req32[CNT_W-1:0];
  assign pid32     = 32'(pid_r);
  assign in_pid32  = 32'(in_process_id);
  assign pid_ok    = pid32 < 32'(PROC_SLOTS);
  assign nxt_pos32 = 32'(scan_pos_r) + 32'd1;
  assign start32   = 32'(seg_start_r);
  assign end32     = 32'(seg_end_r);
  assign largest32 = 32'(run_largest);
  assign scan_done = 32'(scan_pos_r) >= eff32;
  assign seg_done  = seg_ptr_r == seg_end_r;
  assign resp_load = !out_valid_r || out_ready;

  assign map_raddr = (state_r == ST_SCAN && nxt_pos32 < 32'(MEM_UNITS))
                     ? nxt_pos32[ADDR_W-1:0] : '0;

  ffra_bitmap #(
    .MEM_UNITS(MEM_UNITS)
  ) u_bitmap (
    .clk    (clk),
    .map_ctl(map_ctl),
    .waddr  (seg_ptr_r[ADDR_W-1:0]),
    .raddr  (map_raddr),
    .rdata  (map_rdata)
  );

  ffra_slots #(
    .MEM_UNITS (MEM_UNITS),
    .PROC_SLOTS(PROC_SLOTS)
  ) u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .slot_ctl(slot_ctl),
    .rd_idx  (in_pid32[SLOT_W-1:0]),
    .wr_idx  (pid32[SLOT_W-1:0]),
    .wr_start(seg_start_r),
    .wr_end  (seg_end_r),
    .rd_valid(slot_rd_valid),
    .rd_start(slot_rd_start),
    .rd_end  (slot_rd_end)
  );

  ffra_run_unit #(
    .MEM_UNITS(MEM_UNITS)
  ) u_run (
    .clk      (clk),
    .run_ctl  (run_ctl),
    .unit_used(map_rdata),
    .pos      (scan_pos_r),
    .req      (req_cnt),
    .hit      (run_hit),
    .hit_start(run_hit_start),
    .largest  (run_largest)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_region_start = out_start_r;
  assign out_region_end   = out_end_r;
  assign out_largest_free = out_largest_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (seg_ptr_r == CNT_W'(MEM_UNITS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!pid_ok) begin
          state_nxt = ST_RESP;
        end else if (mode_r == MODE_FREE) begin
          state_nxt = slot_rd_valid ? ST_WRITE : ST_RESP;
        end else if (slot_rd_valid || req32 > eff32) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_RESP;
        end else if (run_hit) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (seg_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (resp_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    seg_ptr_nxt     = seg_ptr_r;
    seg_end_nxt     = seg_end_r;
    seg_start_nxt   = seg_start_r;
    scan_pos_nxt    = scan_pos_r;
    res_status_nxt  = res_status_r;
    res_start_nxt   = res_start_r;
    res_end_nxt     = res_end_r;
    res_largest_nxt = res_largest_r;
    map_ctl         = '0;
    run_ctl         = '0;
    slot_ctl        = '0;
    unique case (state_r)
      ST_INIT: begin
        map_ctl.we  = 1'b1;
        seg_ptr_nxt = CNT_W'(seg_ptr_r + 1'b1);
      end
      ST_IDLE: begin
      end
      ST_LOOK: begin
        res_start_nxt   = '0;
        res_end_nxt     = '0;
        res_largest_nxt = '0;
        if (!pid_ok) begin
          res_status_nxt = STAT_EMPTY;
        end else if (mode_r == MODE_FREE) begin
          res_status_nxt = STAT_EMPTY;
          seg_start_nxt  = slot_rd_start;
          seg_ptr_nxt    = slot_rd_start;
          seg_end_nxt    = slot_rd_end;
        end else if (slot_rd_valid) begin
          res_status_nxt = STAT_BUSY;
        end else if (req32 > eff32) begin
          res_status_nxt = STAT_TOO_BIG;
        end else begin
          run_ctl.init = 1'b1;
          scan_pos_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          res_status_nxt  = STAT_NO_FIT;
          res_largest_nxt = largest32[8:0];
        end else begin
          run_ctl.step = 1'b1;
          scan_pos_nxt = CNT_W'(scan_pos_r + 1'b1);
          if (run_hit) begin
            seg_start_nxt = run_hit_start;
            seg_ptr_nxt   = run_hit_start;
            seg_end_nxt   = CNT_W'(run_hit_start + req_cnt);
          end
        end
      end
      ST_WRITE: begin
        if (seg_done) begin
          res_start_nxt = start32[7:0];
          res_end_nxt   = end32[8:0];
          if (mode_r == MODE_ALLOC) begin
            slot_ctl.wr_alloc = 1'b1;
            res_status_nxt    = STAT_ALLOC;
          end else begin
            slot_ctl.wr_free = 1'b1;
            res_status_nxt   = STAT_FREED;
          end
        end else begin
          map_ctl.we    = 1'b1;
          map_ctl.wdata = (mode_r == MODE_ALLOC);
          seg_ptr_nxt   = CNT_W'(seg_ptr_r + 1'b1);
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      seg_ptr_r   <= '0;
      mem_size_r  <= MEM_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seg_ptr_r <= seg_ptr_nxt;
      if (cfg_valid && cfg_ready) begin
        mem_size_r <= cfg_mem_size;
      end
      if (state_r == ST_RESP && resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      pid_r  <= in_process_id;
      req_r  <= in_request_size;
    end
    seg_end_r     <= seg_end_nxt;
    seg_start_r   <= seg_start_nxt;
    scan_pos_r    <= scan_pos_nxt;
    res_status_r  <= res_status_nxt;
    res_start_r   <= res_start_nxt;
    res_end_r     <= res_end_nxt;
    res_largest_r <= res_largest_nxt;
    if (state_r == ST_RESP && resp_load) begin
      out_status_r  <= res_status_r;
      out_start_r   <= res_start_r;
      out_end_r     <= res_end_r;
      out_largest_r <= res_largest_r;
    end
  end

  a_accept_looks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_LOOK)
    else $error("Accepted word did not start a slot lookup.");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |-> seg_ptr_r <= seg_end_r)
    else $error("Region write pointer ran past the region end.");

  a_hit_writes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && !scan_done && run_hit |=> state_r == ST_WRITE)
    else $error("A fitting run did not lead to marking the region.");

endmodule
`default_nettype wire
